// ===== rtl/core/lsws_pkg.sv =====
`default_nettype none
package lsws_pkg;

	localparam int WORD_W    = 32;
	localparam int CAP_W     = 9;
	localparam int CNT_OUT_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_PEEK   = 2'd2,
		FUNC_SEARCH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic                     key_found;
		status_t                  status;
		logic                     now_empty;
		logic                     now_full;
		logic [CNT_OUT_W-1:0]     entry_count;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t data;
	} res_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/lsws_req_if.sv =====
`default_nettype none
interface lsws_req_if;
	logic                             valid;
	logic                             ready;
	lsws_pkg::func_t                  func;
	logic signed [lsws_pkg::WORD_W-1:0] push_value;
	logic signed [lsws_pkg::WORD_W-1:0] search_key;

	modport source(output valid, output func, output push_value, output search_key,
		input ready);
	modport sink(input valid, input func, input push_value, input search_key,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lsws_rsp_if.sv =====
`default_nettype none
interface lsws_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [lsws_pkg::WORD_W-1:0] read_value;
	logic                               key_found;
	lsws_pkg::status_t                  status;
	logic                               now_empty;
	logic                               now_full;
	logic [lsws_pkg::CNT_OUT_W-1:0]     entry_count;

	modport source(output valid, output read_value, output key_found, output status,
		output now_empty, output now_full, output entry_count, input ready);
	modport sink(input valid, input read_value, input key_found, input status,
		input now_empty, input now_full, input entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lifo_stack_with_search_unit.sv =====
// channel   role   handshake          word
// req       sink   valid/ready        func, push_value, search_key
// rsp       source valid/ready        read_value, key_found, status, now_empty,
//                                     now_full, entry_count
// cfg       sink   cfg_we             cfg_wdata (capacity in use)
//
// one word in flight; req is taken again once its result reaches the output register
// push, overflow, underflow, search on empty: idle goes straight to done, then the output register
// pop and peek: idle, read, done, the read state waiting on the registered read of the entry ram
// search: idle, scan, done, one ram read per held entry
// reset empties the stack and sets capacity to 256; ram contents are not cleared
// a stalled rsp holds one result while the next word is worked on
`default_nettype none
module lifo_stack_with_search_unit #(
	parameter int MAX_DEPTH = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lsws_pkg::CAP_W-1:0]  cfg_wdata,
	lsws_req_if.sink                         req,
	lsws_rsp_if.source                       rsp
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int EW = (CW > lsws_pkg::CAP_W) ? CW : lsws_pkg::CAP_W;

	logic [lsws_pkg::CAP_W-1:0]  cap_q;
	logic [EW-1:0]               cap_x;
	logic [CW-1:0]               cap_eff;
	logic                        out_free;
	lsws_pkg::res_word_t         res;
	logic                        out_valid_q;
	lsws_pkg::res_t              out_data_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [lsws_pkg::WORD_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [lsws_pkg::WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lsws_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// saturate capacity to 1 .. MAX_DEPTH
	assign cap_x = EW'(cap_q);
	always_comb begin
		if (cap_x == '0) begin
			cap_eff = CW'(1);
		end else if (cap_x > EW'(MAX_DEPTH)) begin
			cap_eff = CW'(MAX_DEPTH);
		end else begin
			cap_eff = CW'(cap_x);
		end
	end

	lsws_ctrl #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cap_eff  (cap_eff),
		.out_free (out_free),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	lsws_ram #(
		.WIDTH(lsws_pkg::WORD_W),
		.DEPTH(MAX_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
			if (res.valid) begin
				out_data_q <= res.data;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_data_q.read_value;
	assign rsp.key_found   = out_data_q.key_found;
	assign rsp.status      = out_data_q.status;
	assign rsp.now_empty   = out_data_q.now_empty;
	assign rsp.now_full    = out_data_q.now_full;
	assign rsp.entry_count = out_data_q.entry_count;

endmodule
`default_nettype wire

// ===== rtl/core/lsws_ram.sv =====
`default_nettype none
module lsws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lsws_ctrl.sv =====
`default_nettype none
module lsws_ctrl #(
	parameter int MAX_DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	lsws_req_if.sink                                   req,
	input  wire logic [$clog2(MAX_DEPTH+1)-1:0]        cap_eff,
	input  wire logic                                  out_free,
	output lsws_pkg::res_word_t                        res,
	output logic                                       ram_we,
	output logic      [$clog2(MAX_DEPTH)-1:0]          ram_waddr,
	output logic      [lsws_pkg::WORD_W-1:0]           ram_wdata,
	output logic                                       ram_re,
	output logic      [$clog2(MAX_DEPTH)-1:0]          ram_raddr,
	input  wire logic [lsws_pkg::WORD_W-1:0]           ram_rdata
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                scan_q;
	logic                         is_pop_q;
	logic [lsws_pkg::WORD_W-1:0]  key_q;
	logic                         found_q;
	logic [lsws_pkg::WORD_W-1:0]  rv_q;
	lsws_pkg::status_t            status_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic [CW-1:0] cnt_m1;
	logic          hit;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q >= cap_eff);
	assign empty     = (count_q == '0);
	assign cnt_m1    = count_q - CW'(1);
	assign hit       = (ram_rdata == key_q);

	assign ram_we    = accept && (req.func == lsws_pkg::FUNC_PUSH) && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = req.push_value;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && !empty) begin
					case (req.func)
						lsws_pkg::FUNC_POP, lsws_pkg::FUNC_PEEK: begin
							ram_re    = 1'b1;
							ram_raddr = cnt_m1[AW-1:0];
						end
						lsws_pkg::FUNC_SEARCH: begin
							ram_re    = 1'b1;
							ram_raddr = '0;
						end
						default: begin
							ram_re = 1'b0;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_q != count_q) begin
					ram_re    = 1'b1;
					ram_raddr = scan_q[AW-1:0];
				end
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.valid            = (state_q == S_DONE);
		res.data.read_value  = rv_q;
		res.data.key_found   = found_q;
		res.data.status      = status_q;
		res.data.now_empty   = empty;
		res.data.now_full    = full;
		res.data.entry_count = lsws_pkg::CNT_OUT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			is_pop_q <= 1'b0;
			key_q    <= '0;
			found_q  <= 1'b0;
			rv_q     <= '0;
			status_q <= lsws_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q    <= req.search_key;
						is_pop_q <= (req.func == lsws_pkg::FUNC_POP);
						found_q  <= 1'b0;
						rv_q     <= '0;
						status_q <= lsws_pkg::ST_OK;
						scan_q   <= CW'(1);
						case (req.func)
							lsws_pkg::FUNC_PUSH: begin
								if (full) begin
									status_q <= lsws_pkg::ST_OVERFLOW;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							lsws_pkg::FUNC_POP, lsws_pkg::FUNC_PEEK: begin
								if (empty) begin
									status_q <= lsws_pkg::ST_UNDERFLOW;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= empty ? S_DONE : S_SCAN;
							end
						endcase
					end
				end
				S_READ: begin
					rv_q <= ram_rdata;
					if (is_pop_q) begin
						count_q <= cnt_m1;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					found_q <= found_q | hit;
					if (scan_q == count_q) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int STACK_DEPTH = 256;
	localparam int N_PLAN = 25;
	localparam int N_PHASES = 12;

	typedef enum logic {
		ROW_WORD = 1'b0,
		ROW_CAP  = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t                          kind;
		lsws_pkg::func_t                    op;
		logic [lsws_pkg::WORD_W-1:0]        push_value;
		logic [lsws_pkg::WORD_W-1:0]        search_key;
		logic [lsws_pkg::CAP_W-1:0]         cap_value;
		logic                               typed;
		logic [lsws_pkg::WORD_W-1:0]        read_value;
		logic                               key_found;
		lsws_pkg::status_t                  status;
		logic                               now_empty;
		logic                               now_full;
		logic [lsws_pkg::CNT_OUT_W-1:0]     entry_count;
	} plan_row_t;

	// opening rows; expectations typed in where obvious, zero-typed rows go to the predictor
	localparam plan_row_t DIRECTED_PLAN [N_PLAN] = '{
		'{ROW_WORD, lsws_pkg::FUNC_POP, 0, 0, 0, 1, 0, 0,
			lsws_pkg::ST_UNDERFLOW, 1, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PEEK, 0, 0, 0, 1, 0, 0,
			lsws_pkg::ST_UNDERFLOW, 1, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_SEARCH, 0, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OK, 1, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 32'h7fffffff, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 1},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 32'h80000000, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 2},
		'{ROW_WORD, lsws_pkg::FUNC_SEARCH, 0, 32'h80000000, 0, 1, 0, 1,
			lsws_pkg::ST_OK, 0, 0, 2},
		'{ROW_WORD, lsws_pkg::FUNC_SEARCH, 0, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 2},
		'{ROW_WORD, lsws_pkg::FUNC_PEEK, 0, 0, 0, 1, 32'h80000000, 0,
			lsws_pkg::ST_OK, 0, 0, 2},
		'{ROW_CAP, lsws_pkg::FUNC_PUSH, 0, 0, 2, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 1, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OVERFLOW, 0, 1, 2},
		'{ROW_WORD, lsws_pkg::FUNC_POP, 0, 0, 0, 1, 32'h80000000, 0,
			lsws_pkg::ST_OK, 0, 0, 1},
		'{ROW_CAP, lsws_pkg::FUNC_PUSH, 0, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 5, 0, 0, 1, 0, 0,
			lsws_pkg::ST_OVERFLOW, 0, 1, 1},
		'{ROW_WORD, lsws_pkg::FUNC_POP, 0, 0, 0, 1, 32'h7fffffff, 0,
			lsws_pkg::ST_OK, 1, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 32'hffffffff, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 3, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_CAP, lsws_pkg::FUNC_PUSH, 0, 0, 511, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 0, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 32'h55555555, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 32'haaaaaaaa, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_CAP, lsws_pkg::FUNC_PUSH, 0, 0, 1, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_PUSH, 9, 32'h55555555, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_SEARCH, 0, 32'haaaaaaaa, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_POP, 0, 0, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0},
		'{ROW_WORD, lsws_pkg::FUNC_SEARCH, 0, 32'hffffffff, 0, 0, 0, 0,
			lsws_pkg::ST_OK, 0, 0, 0}
	};

	localparam logic [lsws_pkg::CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{
		9'd256, 9'd4, 9'd1, 9'd0, 9'd13, 9'd2, 9'd511, 9'd37, 9'd300, 9'd8, 9'd120, 9'd3
	};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lsws_pkg::CAP_W-1:0]     cfg_wdata;

	lsws_req_if req_bus();
	lsws_rsp_if rsp_bus();

	lifo_stack_with_search_unit #(
		.MAX_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	logic signed [lsws_pkg::WORD_W-1:0] model_words [STACK_DEPTH];
	int                                 model_count;
	logic [lsws_pkg::CAP_W-1:0]         model_cap;
	lsws_pkg::res_t                     due_results [$];
	lsws_pkg::res_t                     due;
	int                                 error_count;
	int                                 idle_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic note_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	function automatic int eff_capacity();
		if (model_cap == 0)
			return 1;
		if (model_cap > STACK_DEPTH)
			return STACK_DEPTH;
		return int'(model_cap);
	endfunction

	// applies one word to the stack copy and returns the result it should give
	function automatic lsws_pkg::res_t next_stack_result(input lsws_pkg::func_t op,
		input logic signed [lsws_pkg::WORD_W-1:0] pv,
		input logic signed [lsws_pkg::WORD_W-1:0] key);
		lsws_pkg::res_t r;
		int             cap;
		cap = eff_capacity();
		r = '0;
		r.status = lsws_pkg::ST_OK;
		case (op)
			lsws_pkg::FUNC_PUSH: begin
				if (model_count >= cap) begin
					r.status = lsws_pkg::ST_OVERFLOW;
				end else begin
					model_words[model_count] = pv;
					model_count++;
				end
			end
			lsws_pkg::FUNC_POP, lsws_pkg::FUNC_PEEK: begin
				if (model_count == 0) begin
					r.status = lsws_pkg::ST_UNDERFLOW;
				end else begin
					r.read_value = model_words[model_count - 1];
					if (op == lsws_pkg::FUNC_POP)
						model_count--;
				end
			end
			default: begin
				for (int i = 0; i < model_count; i++)
					if (model_words[i] == key)
						r.key_found = 1'b1;
			end
		endcase
		r.now_empty = (model_count == 0);
		r.now_full = (model_count >= cap);
		r.entry_count = model_count[lsws_pkg::CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [lsws_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input lsws_pkg::func_t op,
		input logic [lsws_pkg::WORD_W-1:0] pv, input logic [lsws_pkg::WORD_W-1:0] key,
		input logic use_given, input lsws_pkg::res_t given);
		lsws_pkg::res_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			req_bus.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		req_bus.valid <= 1'b1;
		req_bus.func <= op;
		req_bus.push_value <= pv;
		req_bus.search_key <= key;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		predicted = next_stack_result(op, pv, key);
		due_results.push_back(use_given ? given : predicted);
	endtask

	task automatic write_capacity(input logic [lsws_pkg::CAP_W-1:0] value);
		req_bus.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_cap = value;
	endtask

	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (due_results.size() == 0) begin
				note_mismatch("result word with nothing outstanding");
			end else begin
				due = due_results.pop_front();
				if (rsp_bus.read_value !== due.read_value)
					note_mismatch($sformatf("read_value %h, want %h",
						rsp_bus.read_value, due.read_value));
				if (rsp_bus.key_found !== due.key_found)
					note_mismatch($sformatf("key_found %b, want %b",
						rsp_bus.key_found, due.key_found));
				if (rsp_bus.status !== due.status)
					note_mismatch($sformatf("status %0d, want %0d",
						rsp_bus.status, due.status));
				if (rsp_bus.now_empty !== due.now_empty)
					note_mismatch($sformatf("now_empty %b, want %b",
						rsp_bus.now_empty, due.now_empty));
				if (rsp_bus.now_full !== due.now_full)
					note_mismatch($sformatf("now_full %b, want %b",
						rsp_bus.now_full, due.now_full));
				if (rsp_bus.entry_count !== due.entry_count)
					note_mismatch($sformatf("entry_count %0d, want %0d",
						rsp_bus.entry_count, due.entry_count));
			end
		end
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		plan_row_t                   row;
		lsws_pkg::res_t              given;
		int                          budget;
		int                          sent;
		int                          run_len;
		int                          mode;
		int                          pick;
		lsws_pkg::func_t             op;
		logic [lsws_pkg::WORD_W-1:0] pv;
		logic [lsws_pkg::WORD_W-1:0] key;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_bus.valid = 1'b0;
		req_bus.func = lsws_pkg::FUNC_PUSH;
		req_bus.push_value = '0;
		req_bus.search_key = '0;
		rsp_bus.ready = 1'b0;
		error_count = 0;
		idle_pct = 35;
		model_count = 0;
		model_cap = lsws_pkg::CAP_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_PLAN; n++) begin
			row = DIRECTED_PLAN[n];
			if (row.kind == ROW_CAP) begin
				write_capacity(row.cap_value);
			end else begin
				given = '{row.read_value, row.key_found, row.status, row.now_empty,
					row.now_full, row.entry_count};
				send_word(row.op, row.push_value, row.search_key, row.typed, given);
			end
		end

		// fill and drain bursts with mixed runs in between, one capacity per phase
		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(PHASE_CAPS[p]);
			idle_pct = (p == 6) ? 0 : 35;
			budget = 50 + eff_capacity();
			sent = 0;
			while (sent < budget) begin
				mode = $urandom_range(2);
				run_len = $urandom_range(eff_capacity() + 2, 1);
				for (int j = 0; j < run_len && sent < budget; j++) begin
					pick = $urandom_range(99);
					case (mode)
						0: op = (pick < 80) ? lsws_pkg::FUNC_PUSH :
							(pick < 88) ? lsws_pkg::FUNC_SEARCH :
							(pick < 94) ? lsws_pkg::FUNC_PEEK : lsws_pkg::FUNC_POP;
						1: op = (pick < 80) ? lsws_pkg::FUNC_POP :
							(pick < 88) ? lsws_pkg::FUNC_SEARCH :
							(pick < 94) ? lsws_pkg::FUNC_PEEK : lsws_pkg::FUNC_PUSH;
						default: op = lsws_pkg::func_t'($urandom_range(3));
					endcase
					pv = pick_word();
					if (model_count > 0 && $urandom_range(1) == 1)
						key = model_words[$urandom_range(model_count - 1)];
					else
						key = pick_word();
					send_word(op, pv, key, 1'b0, '0);
					sent++;
				end
			end
		end

		req_bus.valid <= 1'b0;
		idle_pct = 35;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/lsws_pkg.sv
rtl/core/lsws_req_if.sv
rtl/core/lsws_rsp_if.sv
rtl/core/lsws_ram.sv
rtl/core/lsws_ctrl.sv
rtl/core/lifo_stack_with_search_unit.sv
tb/tb_top.sv
